[hw/rtl/gdfs_pkg.sv]
// ----------------------------------------------------------------------------
// gdfs_pkg
// Shared types and codes for the depth-first search core: request function
// codes, micro-op and branch condition codes, control word and status bundle.
// ----------------------------------------------------------------------------
package gdfs_pkg;

    // Field widths fixed by the request and result formats
    localparam int FUNC_W  = 2;
    localparam int VERT_W  = 6;
    localparam int COUNT_W = 7;

    // Vertex count after reset
    localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;

    // Request function codes
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_EDGE   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd2;

    // Micro-program address
    localparam int UADDR_W = 5;
    typedef logic [UADDR_W-1:0] t_uaddr;

    // Datapath action of one micro step
    typedef enum logic [3:0] {
        UOP_NOP,
        UOP_FETCH,
        UOP_CLEAR,
        UOP_RD_A,
        UOP_WR_A,
        UOP_RD_B,
        UOP_WR_B,
        UOP_START,
        UOP_RD_CUR,
        UOP_CAND,
        UOP_FIND,
        UOP_PUSH,
        UOP_POP_RD,
        UOP_POP_LD,
        UOP_FIN,
        UOP_BAD
    } t_uop;

    // Branch condition of one micro step
    typedef enum logic [3:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_REQ,
        COND_FUNC_CLR,
        COND_FUNC_EDGE,
        COND_FUNC_SRCH,
        COND_EDGE_BAD,
        COND_START_BAD,
        COND_CAND_ZERO,
        COND_OUT_BUSY,
        COND_SP_ZERO
    } t_cond;

    // One control word of the micro-program
    typedef struct packed {
        t_uop   uop;
        t_cond  cond;
        t_uaddr target;
    } t_uword;

    // Datapath flags the sequencer branches on
    typedef struct packed {
        logic no_req;
        logic func_clr;
        logic func_edge;
        logic func_srch;
        logic edge_bad;
        logic start_bad;
        logic cand_zero;
        logic out_busy;
        logic sp_zero;
    } t_stat;

endpackage

[hw/rtl/gdfs_sequencer.sv]
// ----------------------------------------------------------------------------
// gdfs_sequencer
// Step counter and micro-program ROM. Each step issues one control word and
// either falls through or jumps, unconditionally or on a datapath flag.
// ----------------------------------------------------------------------------
module gdfs_sequencer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  gdfs_pkg::t_stat i_stat,
    output gdfs_pkg::t_uword o_uword
);

    // Program labels
    localparam gdfs_pkg::t_uaddr A_FETCH  = 5'd0;
    localparam gdfs_pkg::t_uaddr A_CLR    = 5'd5;
    localparam gdfs_pkg::t_uaddr A_EDGE   = 5'd6;
    localparam gdfs_pkg::t_uaddr A_SRCH   = 5'd11;
    localparam gdfs_pkg::t_uaddr A_LOOP   = 5'd13;
    localparam gdfs_pkg::t_uaddr A_EMIT   = 5'd17;
    localparam gdfs_pkg::t_uaddr A_POP    = 5'd19;
    localparam gdfs_pkg::t_uaddr A_FINISH = 5'd22;
    localparam gdfs_pkg::t_uaddr A_BADOUT = 5'd24;

    // Micro-program
    function automatic gdfs_pkg::t_uword rom(input gdfs_pkg::t_uaddr a);
        gdfs_pkg::t_uword w;
        w = '{uop: gdfs_pkg::UOP_NOP, cond: gdfs_pkg::COND_ALWAYS, target: A_FETCH};
        unique case (a)
            // idle: wait for a request, then dispatch on its function
            5'd0:  w = '{gdfs_pkg::UOP_FETCH,  gdfs_pkg::COND_NO_REQ,    A_FETCH};
            5'd1:  w = '{gdfs_pkg::UOP_NOP,    gdfs_pkg::COND_FUNC_CLR,  A_CLR};
            5'd2:  w = '{gdfs_pkg::UOP_NOP,    gdfs_pkg::COND_FUNC_EDGE, A_EDGE};
            5'd3:  w = '{gdfs_pkg::UOP_NOP,    gdfs_pkg::COND_FUNC_SRCH, A_SRCH};
            5'd4:  w = '{gdfs_pkg::UOP_NOP,    gdfs_pkg::COND_ALWAYS,    A_FETCH};
            // clear graph
            5'd5:  w = '{gdfs_pkg::UOP_CLEAR,  gdfs_pkg::COND_ALWAYS,    A_FETCH};
            // add edge: read-modify-write row a, then row b
            5'd6:  w = '{gdfs_pkg::UOP_NOP,    gdfs_pkg::COND_EDGE_BAD,  A_FETCH};
            5'd7:  w = '{gdfs_pkg::UOP_RD_A,   gdfs_pkg::COND_NEVER,     A_FETCH};
            5'd8:  w = '{gdfs_pkg::UOP_WR_A,   gdfs_pkg::COND_NEVER,     A_FETCH};
            5'd9:  w = '{gdfs_pkg::UOP_RD_B,   gdfs_pkg::COND_NEVER,     A_FETCH};
            5'd10: w = '{gdfs_pkg::UOP_WR_B,   gdfs_pkg::COND_ALWAYS,    A_FETCH};
            // search setup
            5'd11: w = '{gdfs_pkg::UOP_NOP,    gdfs_pkg::COND_START_BAD, A_BADOUT};
            5'd12: w = '{gdfs_pkg::UOP_START,  gdfs_pkg::COND_NEVER,     A_FETCH};
            // walk: fetch row of top vertex, look for an unvisited neighbor
            5'd13: w = '{gdfs_pkg::UOP_RD_CUR, gdfs_pkg::COND_NEVER,     A_FETCH};
            5'd14: w = '{gdfs_pkg::UOP_CAND,   gdfs_pkg::COND_NEVER,     A_FETCH};
            5'd15: w = '{gdfs_pkg::UOP_NOP,    gdfs_pkg::COND_CAND_ZERO, A_POP};
            5'd16: w = '{gdfs_pkg::UOP_FIND,   gdfs_pkg::COND_NEVER,     A_FETCH};
            // descend: wait for the output register, emit and push
            5'd17: w = '{gdfs_pkg::UOP_NOP,    gdfs_pkg::COND_OUT_BUSY,  A_EMIT};
            5'd18: w = '{gdfs_pkg::UOP_PUSH,   gdfs_pkg::COND_ALWAYS,    A_LOOP};
            // backtrack: pop the parent, or finish on an empty stack
            5'd19: w = '{gdfs_pkg::UOP_NOP,    gdfs_pkg::COND_SP_ZERO,   A_FINISH};
            5'd20: w = '{gdfs_pkg::UOP_POP_RD, gdfs_pkg::COND_NEVER,     A_FETCH};
            5'd21: w = '{gdfs_pkg::UOP_POP_LD, gdfs_pkg::COND_ALWAYS,    A_LOOP};
            // final result carries last
            5'd22: w = '{gdfs_pkg::UOP_NOP,    gdfs_pkg::COND_OUT_BUSY,  A_FINISH};
            5'd23: w = '{gdfs_pkg::UOP_FIN,    gdfs_pkg::COND_ALWAYS,    A_FETCH};
            // out-of-range start
            5'd24: w = '{gdfs_pkg::UOP_NOP,    gdfs_pkg::COND_OUT_BUSY,  A_BADOUT};
            5'd25: w = '{gdfs_pkg::UOP_BAD,    gdfs_pkg::COND_ALWAYS,    A_FETCH};
            default: w = '{gdfs_pkg::UOP_NOP,  gdfs_pkg::COND_ALWAYS,    A_FETCH};
        endcase
        return w;
    endfunction

    gdfs_pkg::t_uaddr r_pc;
    gdfs_pkg::t_uaddr n_pc;
    gdfs_pkg::t_uword uword;
    logic             take;

    assign uword   = rom(r_pc);
    assign o_uword = uword;

    // Branch condition select
    always_comb begin
        unique case (uword.cond)
            gdfs_pkg::COND_NEVER:     take = 1'b0;
            gdfs_pkg::COND_ALWAYS:    take = 1'b1;
            gdfs_pkg::COND_NO_REQ:    take = i_stat.no_req;
            gdfs_pkg::COND_FUNC_CLR:  take = i_stat.func_clr;
            gdfs_pkg::COND_FUNC_EDGE: take = i_stat.func_edge;
            gdfs_pkg::COND_FUNC_SRCH: take = i_stat.func_srch;
            gdfs_pkg::COND_EDGE_BAD:  take = i_stat.edge_bad;
            gdfs_pkg::COND_START_BAD: take = i_stat.start_bad;
            gdfs_pkg::COND_CAND_ZERO: take = i_stat.cand_zero;
            gdfs_pkg::COND_OUT_BUSY:  take = i_stat.out_busy;
            gdfs_pkg::COND_SP_ZERO:   take = i_stat.sp_zero;
            default:                  take = 1'b0;
        endcase
        n_pc = take ? uword.target : r_pc + 5'd1;
    end

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= A_FETCH;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

[hw/rtl/gdfs_datapath.sv]
// ----------------------------------------------------------------------------
// gdfs_datapath
// Adjacency row memory, visited marks, parent stack, neighbor search and the
// result registers, driven one micro-op per cycle by the sequencer.
// ----------------------------------------------------------------------------
module gdfs_datapath #(
    parameter int MAX_NODES = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  gdfs_pkg::t_uword               i_uword,
    output gdfs_pkg::t_stat                o_stat,
    // request channel
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [gdfs_pkg::FUNC_W-1:0]    i_func,
    input  logic [gdfs_pkg::VERT_W-1:0]    i_vertex_a,
    input  logic [gdfs_pkg::VERT_W-1:0]    i_vertex_b,
    // result channel
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [gdfs_pkg::VERT_W-1:0]    o_reached_vertex,
    output logic                           o_last,
    output logic                           o_bad_start,
    // vertex count register
    input  logic                           i_cfg_we,
    input  logic [gdfs_pkg::COUNT_W-1:0]   i_cfg_data
);

    localparam int IDXW = $clog2(MAX_NODES);
    localparam logic [MAX_NODES-1:0] ONE = {{(MAX_NODES-1){1'b0}}, 1'b1};
    localparam logic [gdfs_pkg::COUNT_W-1:0] MAX_CNT = gdfs_pkg::COUNT_W'(MAX_NODES);

    gdfs_pkg::t_uop uop;
    assign uop = i_uword.uop;

    // Request latch and vertex count
    logic [gdfs_pkg::FUNC_W-1:0]  r_func;
    logic [gdfs_pkg::VERT_W-1:0]  r_a;
    logic [gdfs_pkg::VERT_W-1:0]  r_b;
    logic [gdfs_pkg::COUNT_W-1:0] r_vcount;
    logic [gdfs_pkg::COUNT_W-1:0] live_n;
    logic [MAX_NODES-1:0]         usable;
    logic [IDXW-1:0]              a_idx;
    logic [IDXW-1:0]              b_idx;
    logic                         req_fire;

    assign o_ready  = (uop == gdfs_pkg::UOP_FETCH);
    assign req_fire = i_valid && o_ready;
    assign a_idx    = r_a[IDXW-1:0];
    assign b_idx    = r_b[IDXW-1:0];

    always_comb begin
        live_n = (r_vcount < MAX_CNT) ? r_vcount : MAX_CNT;
        for (int k = 0; k < MAX_NODES; k++) begin
            usable[k] = (gdfs_pkg::COUNT_W'(k) < live_n);
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_func <= i_func;
            r_a    <= i_vertex_a;
            r_b    <= i_vertex_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= gdfs_pkg::COUNT_RESET;
        end else if (i_cfg_we) begin
            r_vcount <= i_cfg_data;
        end
    end

    // Adjacency rows: one memory row per vertex, valid bits give clear-to-zero
    logic [MAX_NODES-1:0] r_rows [MAX_NODES];
    logic [MAX_NODES-1:0] r_row_ok;
    logic [MAX_NODES-1:0] r_rdata;
    logic                 r_rdok;
    logic [MAX_NODES-1:0] row;
    logic [IDXW-1:0]      rd_idx;
    logic                 rd_en;
    logic [IDXW-1:0]      wr_idx;
    logic [MAX_NODES-1:0] wr_row;
    logic                 wr_en;

    // Search state
    logic [MAX_NODES-1:0] r_visited;
    logic [MAX_NODES-1:0] r_cand;
    logic [IDXW-1:0]      r_cur;
    logic [IDXW-1:0]      r_j;
    logic [IDXW-1:0]      first_idx;
    logic [IDXW-1:0]      r_hold;

    // Parent stack
    logic [IDXW-1:0]      r_stack [MAX_NODES];
    logic [IDXW-1:0]      r_sp;
    logic [IDXW-1:0]      r_stk_q;

    assign row = r_rdok ? r_rdata : '0;

    // Row port address and write data select
    always_comb begin
        rd_en  = 1'b0;
        rd_idx = r_cur;
        wr_en  = 1'b0;
        wr_idx = a_idx;
        wr_row = row | (ONE << b_idx);
        unique case (uop)
            gdfs_pkg::UOP_RD_A: begin
                rd_en  = 1'b1;
                rd_idx = a_idx;
            end
            gdfs_pkg::UOP_RD_B: begin
                rd_en  = 1'b1;
                rd_idx = b_idx;
            end
            gdfs_pkg::UOP_RD_CUR: begin
                rd_en  = 1'b1;
            end
            gdfs_pkg::UOP_WR_A: begin
                wr_en  = 1'b1;
            end
            gdfs_pkg::UOP_WR_B: begin
                wr_en  = 1'b1;
                wr_idx = b_idx;
                wr_row = row | (ONE << a_idx);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_rows[wr_idx] <= wr_row;
        end
        if (rd_en) begin
            r_rdata <= r_rows[rd_idx];
            r_rdok  <= r_row_ok[rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_ok <= '0;
        end else if (uop == gdfs_pkg::UOP_CLEAR) begin
            r_row_ok <= '0;
        end else if (wr_en) begin
            r_row_ok[wr_idx] <= 1'b1;
        end
    end

    // Lowest set bit of the candidate set
    always_comb begin
        first_idx = '0;
        for (int i = MAX_NODES - 1; i >= 0; i--) begin
            if (r_cand[i]) begin
                first_idx = IDXW'(i);
            end
        end
    end

    // Stack memory
    always_ff @(posedge i_clk) begin
        if (uop == gdfs_pkg::UOP_PUSH) begin
            r_stack[r_sp] <= r_cur;
        end
        if (uop == gdfs_pkg::UOP_POP_RD) begin
            r_stk_q <= r_stack[r_sp - IDXW'(1)];
        end
    end

    // Walk registers; lower neighbors stay visited, so no resume index is kept
    always_ff @(posedge i_clk) begin
        case (uop)
            gdfs_pkg::UOP_START: begin
                r_visited <= ONE << a_idx;
                r_cur     <= a_idx;
                r_hold    <= a_idx;
                r_sp      <= '0;
            end
            gdfs_pkg::UOP_CAND: begin
                r_cand <= row & ~r_visited & usable;
            end
            gdfs_pkg::UOP_FIND: begin
                r_j <= first_idx;
            end
            gdfs_pkg::UOP_PUSH: begin
                r_visited[r_j] <= 1'b1;
                r_cur          <= r_j;
                r_hold         <= r_j;
                r_sp           <= r_sp + IDXW'(1);
            end
            gdfs_pkg::UOP_POP_RD: begin
                r_sp <= r_sp - IDXW'(1);
            end
            gdfs_pkg::UOP_POP_LD: begin
                r_cur <= r_stk_q;
            end
            default: begin
            end
        endcase
    end

    // Result register: the held vertex goes out once the next one is known
    logic                        r_out_valid;
    logic [gdfs_pkg::VERT_W-1:0] r_out_vertex;
    logic                        r_out_last;
    logic                        r_out_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (uop)
                gdfs_pkg::UOP_PUSH: begin
                    r_out_valid  <= 1'b1;
                    r_out_vertex <= gdfs_pkg::VERT_W'(r_hold);
                    r_out_last   <= 1'b0;
                    r_out_bad    <= 1'b0;
                end
                gdfs_pkg::UOP_FIN: begin
                    r_out_valid  <= 1'b1;
                    r_out_vertex <= gdfs_pkg::VERT_W'(r_hold);
                    r_out_last   <= 1'b1;
                    r_out_bad    <= 1'b0;
                end
                gdfs_pkg::UOP_BAD: begin
                    r_out_valid  <= 1'b1;
                    r_out_vertex <= '0;
                    r_out_last   <= 1'b1;
                    r_out_bad    <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_valid          = r_out_valid;
    assign o_reached_vertex = r_out_vertex;
    assign o_last           = r_out_last;
    assign o_bad_start      = r_out_bad;

    // Flags for the sequencer
    always_comb begin
        o_stat.no_req    = !i_valid;
        o_stat.func_clr  = (r_func == gdfs_pkg::FUNC_CLEAR);
        o_stat.func_edge = (r_func == gdfs_pkg::FUNC_EDGE);
        o_stat.func_srch = (r_func == gdfs_pkg::FUNC_SEARCH);
        o_stat.edge_bad  = ({1'b0, r_a} >= live_n) || ({1'b0, r_b} >= live_n);
        o_stat.start_bad = ({1'b0, r_a} >= live_n);
        o_stat.cand_zero = (r_cand == '0);
        o_stat.out_busy  = r_out_valid;
        o_stat.sp_zero   = (r_sp == '0);
    end

endmodule

[hw/rtl/graph_depth_first_search_core.sv]
// ----------------------------------------------------------------------------
// graph_depth_first_search_core
// Depth-first search over an undirected graph held as a bit adjacency matrix,
// run by a micro-programmed sequencer over a row memory and a parent stack.
// ----------------------------------------------------------------------------
//  channel   | handshake          | payload
//  ----------+--------------------+------------------------------------------
//  request   | i_valid / o_ready  | i_func, i_vertex_a, i_vertex_b
//  result    | o_valid / i_ready  | o_reached_vertex, o_last, o_bad_start
//  config    | i_cfg_we           | i_cfg_data (vertex count)
//
//  A request is taken only at the idle step, then dispatched on its function code.
//  Descent and backtrack in a search share the single row memory port, and a
//  backtrack reads the parent stack through a register.
//  Synchronous active-low reset; rows read as zero after reset or clear.
//  A waiting result stalls the walk only when the next result is ready.
// ----------------------------------------------------------------------------
module graph_depth_first_search_core #(
    parameter int MAX_NODES = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [gdfs_pkg::FUNC_W-1:0]  i_func,
    input  logic [gdfs_pkg::VERT_W-1:0]  i_vertex_a,
    input  logic [gdfs_pkg::VERT_W-1:0]  i_vertex_b,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [gdfs_pkg::VERT_W-1:0]  o_reached_vertex,
    output logic                         o_last,
    output logic                         o_bad_start,
    input  logic                         i_cfg_we,
    input  logic [gdfs_pkg::COUNT_W-1:0] i_cfg_data
);

    gdfs_pkg::t_uword uword;
    gdfs_pkg::t_stat  stat;

    // Control store and step counter
    gdfs_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_uword (uword)
    );

    // Graph storage and walk datapath
    gdfs_datapath #(
        .MAX_NODES (MAX_NODES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_uword          (uword),
        .o_stat           (stat),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_func           (i_func),
        .i_vertex_a       (i_vertex_a),
        .i_vertex_b       (i_vertex_b),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_reached_vertex (o_reached_vertex),
        .o_last           (o_last),
        .o_bad_start      (o_bad_start),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data)
    );

endmodule

[hw/rtl/gdfs_checker.sv]
// ----------------------------------------------------------------------------
// gdfs_checker
// Port-level checks for the depth-first search core, bound to the top level.
// ----------------------------------------------------------------------------
module gdfs_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_ready,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic [gdfs_pkg::VERT_W-1:0] o_reached_vertex,
    input logic                        o_last,
    input logic                        o_bad_start
);

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_reached_vertex)
            && $stable(o_last) && $stable(o_bad_start))
        else $error("result changed while stalled");

    // Bad start is a lone result on vertex zero
    a_bad_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_bad_start |-> o_last && (o_reached_vertex == '0))
        else $error("bad start result malformed");

    // No result right out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // A taken request leaves the idle step, so no request follows at once
    a_req_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("back-to-back request taken");

endmodule

bind graph_depth_first_search_core gdfs_checker u_chk (.*);
